FILE: rtl/plids_pkg.sv
// Shared widths, operation codes and controller/datapath interface types for the positional list.
package plids_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clr_res;
        logic set_reject;
        logic cur_init;
        logic rd;
        logic wr_shift;
        logic cur_step;
        logic wr_val;
        logic cnt_inc;
        logic cnt_dec;
        logic set_found;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_srch;
        logic ins_ok;
        logic del_ok;
        logic more;
        logic match;
    } sts_t;

endpackage

FILE: rtl/plids_ctrl.sv
// Sequencer for insert, delete and search requests of the positional list.
module plids_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  plids_pkg::sts_t sts,
    output plids_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOP,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   can_out;
    logic   op_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign can_out   = !out_valid_reg || out_ready;
    assign op_ok     = (sts.is_ins && sts.ins_ok) || (sts.is_del && sts.del_ok) || sts.is_srch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    state_reg <= op_ok ? ST_LOOP : ST_DONE;
                end
                ST_LOOP:
                begin
                    state_reg <= sts.more ? ST_READ : ST_DONE;
                end
                ST_READ:
                begin
                    state_reg <= (sts.is_srch && sts.match) ? ST_DONE : ST_LOOP;
                end
                ST_DONE:
                begin
                    if (can_out)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (state_reg == ST_DONE && can_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load    = in_valid;
                cmd.clr_res = in_valid;
            end
            ST_CHECK:
            begin
                cmd.cur_init   = op_ok;
                cmd.set_reject = !op_ok;
            end
            ST_LOOP:
            begin
                if (sts.more)
                    cmd.rd = 1'b1;
                else if (sts.is_ins)
                begin
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                else if (sts.is_del)
                    cmd.cnt_dec = 1'b1;
            end
            ST_READ:
            begin
                priority if (sts.is_srch)
                begin
                    cmd.set_found = sts.match;
                    cmd.cur_step  = !sts.match;
                end
                else
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.cur_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = can_out;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/plids_dp.sv
// List storage, count, walk cursor and result registers of the positional list.
module plids_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic        [plids_pkg::MODE_W-1:0]    mode,
    input  logic        [plids_pkg::POS_W-1:0]     position,
    input  logic signed [plids_pkg::DATA_W-1:0]    value,
    output logic                                   status,
    output logic                                   found,
    output logic        [plids_pkg::IDX_W-1:0]     match_index,
    output logic        [plids_pkg::CNT_W-1:0]     entry_count,
    input  plids_pkg::cmd_t                        cmd,
    output plids_pkg::sts_t                        sts
);

    localparam int CNT_W = plids_pkg::CNT_W;
    localparam int IDX_W = plids_pkg::IDX_W;
    localparam int POS_W = plids_pkg::POS_W;

    logic [plids_pkg::DATA_W-1:0] mem [plids_pkg::CAPACITY];

    logic [plids_pkg::MODE_W-1:0] op_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [plids_pkg::DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [CNT_W-1:0]             cur_reg;
    logic [plids_pkg::DATA_W-1:0] rdata_reg;
    logic                         res_status_reg;
    logic                         res_found_reg;
    logic [IDX_W-1:0]             res_index_reg;
    logic                         out_status_reg;
    logic                         out_found_reg;
    logic [IDX_W-1:0]             out_index_reg;
    logic [CNT_W-1:0]             out_count_reg;

    logic [CNT_W:0]     cnt_p1;
    logic [CNT_W:0]     cur_p1;
    logic [CNT_W-1:0]   cur_m1;
    logic [POS_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   cur_init_val;
    logic [CNT_W-1:0]   cur_step_val;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [plids_pkg::DATA_W-1:0] wr_data;
    logic               wr_en;
    logic               is_ins;
    logic               is_del;
    logic               is_srch;

    assign is_ins  = (op_reg == plids_pkg::MODE_INSERT);
    assign is_del  = (op_reg == plids_pkg::MODE_DELETE);
    assign is_srch = (op_reg == plids_pkg::MODE_SEARCH);

    assign cnt_p1 = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign cur_p1 = {1'b0, cur_reg} + (CNT_W+1)'(1);
    assign cur_m1 = cur_reg - CNT_W'(1);
    assign pos_m1 = pos_reg - POS_W'(1);

    always_comb
    begin
        sts         = '0;
        sts.is_ins  = is_ins;
        sts.is_del  = is_del;
        sts.is_srch = is_srch;
        sts.ins_ok  = (pos_reg != '0) && ((CNT_W+1)'(pos_reg) <= cnt_p1)
                      && ((CNT_W+1)'(pos_reg) <= (CNT_W+1)'(plids_pkg::CAPACITY));
        sts.del_ok  = (pos_reg != '0) && (CNT_W'(pos_reg) <= cnt_reg);
        sts.match   = (rdata_reg == val_reg);
        priority if (is_ins)
            sts.more = (cur_reg >= CNT_W'(pos_reg));
        else if (is_del)
            sts.more = (cur_p1 < {1'b0, cnt_reg});
        else
            sts.more = (cur_reg < cnt_reg);
    end

    // Cursor start, step and read address per operation
    always_comb
    begin
        priority if (is_ins)
        begin
            cur_init_val = (cnt_reg < CNT_W'(plids_pkg::CAPACITY))
                           ? cnt_reg : CNT_W'(plids_pkg::CAPACITY - 1);
            cur_step_val = cur_m1;
            rd_addr      = cur_m1[IDX_W-1:0];
        end
        else if (is_del)
        begin
            cur_init_val = CNT_W'(pos_m1);
            cur_step_val = cur_p1[CNT_W-1:0];
            rd_addr      = cur_p1[IDX_W-1:0];
        end
        else
        begin
            cur_init_val = '0;
            cur_step_val = cur_p1[CNT_W-1:0];
            rd_addr      = cur_reg[IDX_W-1:0];
        end
    end

    assign wr_en   = cmd.wr_shift || cmd.wr_val;
    assign wr_addr = cmd.wr_val ? pos_m1[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_val ? val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
            rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc && (cnt_reg != CNT_W'(plids_pkg::CAPACITY)))
            cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= mode;
            pos_reg <= position;
            val_reg <= value;
        end

        if (cmd.cur_init)
            cur_reg <= cur_init_val;
        else if (cmd.cur_step)
            cur_reg <= cur_step_val;

        if (cmd.clr_res)
        begin
            res_status_reg <= 1'b0;
            res_found_reg  <= 1'b0;
            res_index_reg  <= '0;
        end
        else if (cmd.set_reject)
            res_status_reg <= 1'b1;
        else if (cmd.set_found)
        begin
            res_found_reg <= 1'b1;
            res_index_reg <= cur_reg[IDX_W-1:0];
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_index_reg  <= res_index_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign match_index = out_index_reg;
    assign entry_count = out_count_reg;

endmodule

FILE: rtl/positional_list_insert_delete_search.sv
// Top level of the positional list: insert, delete and first-match search on an ordered list.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------------
//  request   | in_valid / in_ready  | mode, position, value
//  result    | out_valid / out_ready| status, found, match_index, entry_count
//
// One request at a time, taken in idle. A rejected request goes straight to the result;
// otherwise each entry that moves (insert, delete) or is compared (search) needs one read
// and then one write or compare, and a search stops at its first hit. After a result is
// delivered, the sequencer passes through idle again before it takes the next request.
// Reset clears the entry count and the control state; list contents stay undefined.
// A finished result holds in the output register while the next request is taken;
// if the result is still not taken when the next one finishes, the sequencer holds.
module positional_list_insert_delete_search
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic        [plids_pkg::MODE_W-1:0] mode,
    input  logic        [plids_pkg::POS_W-1:0]  position,
    input  logic signed [plids_pkg::DATA_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic                                found,
    output logic        [plids_pkg::IDX_W-1:0]  match_index,
    output logic        [plids_pkg::CNT_W-1:0]  entry_count
);

    // Commands drive the datapath; status flags steer the sequencer.
    plids_pkg::cmd_t cmd;
    plids_pkg::sts_t sts;

    // Sequencer: decode, walk the list one entry per read and write-or-compare pair, deliver.
    plids_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: list memory, count, cursor, comparator and result register.
    plids_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .status      (status),
        .found       (found),
        .match_index (match_index),
        .entry_count (entry_count),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: verif/tb_positional_list_insert_delete_search.sv
// Testbench for the positional list: a directed table, then random phases checked against a shadow list.
`timescale 1ns / 100ps

module tb_positional_list_insert_delete_search;

    localparam int CAPACITY = plids_pkg::CAPACITY;
    localparam int DATA_W   = plids_pkg::DATA_W;
    localparam int MODE_W   = plids_pkg::MODE_W;
    localparam int POS_W    = plids_pkg::POS_W;
    localparam int IDX_W    = plids_pkg::IDX_W;
    localparam int CNT_W    = plids_pkg::CNT_W;

    localparam logic [MODE_W-1:0] MODE_INSERT = plids_pkg::MODE_INSERT;
    localparam logic [MODE_W-1:0] MODE_DELETE = plids_pkg::MODE_DELETE;
    localparam logic [MODE_W-1:0] MODE_SEARCH = plids_pkg::MODE_SEARCH;

    localparam int CLK_PERIOD  = 8;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 1900;
    // Allows for the worst-case request plus the longest stall on
    // either side; take that over every request several times.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;

    // The one mode code the package leaves unused; the block must reject it.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_NEG = 32'shffff_ffff;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [IDX_W-1:0]  match_index;
        logic [CNT_W-1:0]  entry_count;
    } res_t;

    // One line of the directed table: the request, and a hand-written result
    // where "typed" is set (otherwise the shadow list supplies it).
    typedef struct packed {
        req_t rq;
        logic typed;
        res_t want;
    } row_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_LOOKUP} phase_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     status;
    logic                     found;
    logic [IDX_W-1:0]         match_index;
    logic [CNT_W-1:0]         entry_count;

    // Shadow copy of the list and its length, advanced once per accepted request.
    logic signed [DATA_W-1:0] list_shadow [CAPACITY];
    int                       list_len;

    // Results still owed by the block, oldest first.
    res_t                     due_results[$];
    res_t                     head;
    row_t                     plan [N_DIRECTED];

    int n_sent;
    int n_errors;
    int n_rejects;
    int n_hits;
    int n_full_inserts;
    int n_in_stalls;
    int peak_len;
    int cycles;

    positional_list_insert_delete_search i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .match_index (match_index),
        .entry_count (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one request to the shadow list and return the result it must produce.
    function automatic res_t list_apply(input req_t rq);
        res_t o;
        int   p;
        int   i;
        int   top;
        o = '0;
        p = rq.position;
        case (rq.mode)
            MODE_INSERT:
            begin
                if (p < 1 || p > list_len + 1 || p > CAPACITY)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    // On a full list the last entry falls off the end.
                    if (list_len == CAPACITY)
                        n_full_inserts++;
                    top = (list_len < CAPACITY) ? list_len : CAPACITY - 1;
                    for (i = top; i > p - 1; i--)
                        list_shadow[i] = list_shadow[i - 1];
                    list_shadow[p - 1] = rq.value;
                    if (list_len < CAPACITY)
                        list_len++;
                end
            end
            MODE_DELETE:
            begin
                if (p < 1 || p > list_len)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_shadow[i] = list_shadow[i + 1];
                    list_len--;
                end
            end
            MODE_SEARCH:
            begin
                for (i = 0; i < list_len && !o.found; i++)
                begin
                    if (list_shadow[i] == rq.value)
                    begin
                        o.found       = 1'b1;
                        o.match_index = IDX_W'(i);
                    end
                end
                if (o.found)
                    n_hits++;
            end
            default:
            begin
                o.status = 1'b1;
            end
        endcase
        if (o.status)
            n_rejects++;
        if (list_len > peak_len)
            peak_len = list_len;
        o.entry_count = CNT_W'(list_len);
        return o;
    endfunction

    function automatic row_t make_row(input logic [MODE_W-1:0] m, input int p,
                                      input logic signed [DATA_W-1:0] v, input bit typed,
                                      input bit st, input bit fnd, input int idx, input int cnt);
        row_t r;
        r.rq.mode              = m;
        r.rq.position          = POS_W'(p);
        r.rq.value             = v;
        r.typed                = typed;
        r.want.status          = st;
        r.want.found           = fnd;
        r.want.match_index     = IDX_W'(idx);
        r.want.entry_count     = CNT_W'(cnt);
        return r;
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_SPARE;
        case (ph)
            PH_FILL:
                return (r < 85) ? MODE_INSERT : (r < 93) ? MODE_SEARCH : MODE_DELETE;
            PH_DRAIN:
                return (r < 15) ? MODE_INSERT : (r < 80) ? MODE_DELETE : MODE_SEARCH;
            PH_MIXED:
                return (r < 40) ? MODE_INSERT : (r < 70) ? MODE_DELETE : MODE_SEARCH;
            default:
                return (r < 15) ? MODE_INSERT : (r < 25) ? MODE_DELETE : MODE_SEARCH;
        endcase
    endfunction

    // Mostly legal positions with the ends favored; the rest is noise over the field.
    function automatic logic [POS_W-1:0] pick_position(input logic [MODE_W-1:0] m);
        int r;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 12 || (m != MODE_INSERT && m != MODE_DELETE))
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (m == MODE_INSERT)
        begin
            hi = (list_len + 1 < CAPACITY) ? list_len + 1 : CAPACITY;
            if (r < 20)
                return POS_W'(1);
            else if (r < 28)
                return POS_W'(hi);
            else if (r < 32)
                return POS_W'(list_len + 1);
            return POS_W'($urandom_range(1, hi));
        end
        if (list_len == 0)
            return POS_W'($urandom_range(0, 3));
        if (r < 20)
            return POS_W'(1);
        else if (r < 28)
            return POS_W'(list_len);
        return POS_W'($urandom_range(1, list_len));
    endfunction

    // Searches mostly look for stored values; a small pool makes duplicates common.
    function automatic logic signed [DATA_W-1:0] pick_value(input logic [MODE_W-1:0] m);
        int r;
        r = $urandom_range(0, 99);
        if (m == MODE_SEARCH && list_len > 0 && r < 60)
            return list_shadow[$urandom_range(0, list_len - 1)];
        if (r < 75)
            return $signed($urandom_range(0, 4)) - 2;
        if (r < 80)
            return ($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX;
        return $urandom;
    endfunction

    // Offer one request after the given gap, hold it until accepted, then
    // record the result it owes.
    task automatic send_request(input req_t rq, input int gap, input bit typed,
                                input res_t want);
        res_t outcome;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= rq.mode;
        position <= rq.position;
        value    <= rq.value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        outcome = list_apply(rq);
        if (typed)
            outcome = want;
        due_results.push_back(outcome);
        n_sent++;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
        end
    endtask

    // Result checker: compare every accepted result against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                n_in_stalls++;
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with none owed, expected nothing, actual status %0d count %0d",
                             $time, status, entry_count);
                end
                else
                begin
                    head = due_results.pop_front();
                    check_field("status", 32'(head.status), 32'(status));
                    check_field("found", 32'(head.found), 32'(found));
                    check_field("match_index", 32'(head.match_index), 32'(match_index));
                    check_field("entry_count", 32'(head.entry_count), 32'(entry_count));
                end
            end
        end
    end

    // Result side: random runs of ready and stall, plus one long hold-off that
    // backs results up until the block stops taking requests.
    initial
    begin
        int run;
        int r;
        bit lvl;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && n_sent >= 600)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                lvl = 1'b1;
                run = $urandom_range(1, 40);
            end
            else if (r < 90)
            begin
                lvl = 1'b0;
                run = $urandom_range(1, 4);
            end
            else if (r < 98)
            begin
                lvl = 1'b0;
                run = $urandom_range(5, 20);
            end
            else
            begin
                lvl = 1'b0;
                run = $urandom_range(30, 80);
            end
            repeat (run)
            begin
                @(negedge clk);
                out_ready <= lvl;
            end
        end
    end

    // Watchdog: give up if the run outlasts any plausible correct schedule.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_positional_list_insert_delete_search: done, errors");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial
    begin
        int     k;
        int     n_random;
        int     ph_len;
        bit     burst;
        phase_t ph;
        req_t   rq;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_INSERT;
        position       = '0;
        value          = '0;
        list_len       = 0;
        n_sent         = 0;
        n_errors       = 0;
        n_rejects      = 0;
        n_hits         = 0;
        n_full_inserts = 0;
        n_in_stalls    = 0;
        peak_len       = 0;

        // Directed table. Typed rows carry results readable at a glance:
        // empty-list cases, rejects, and inserts and searches around extreme values.
        plan[0]  = make_row(MODE_SEARCH, 0,   0,       1, 0, 0, 0, 0); // search of empty list
        plan[1]  = make_row(MODE_DELETE, 1,   0,       1, 1, 0, 0, 0); // delete from empty list
        plan[2]  = make_row(MODE_INSERT, 0,   5,       1, 1, 0, 0, 0); // position zero
        plan[3]  = make_row(MODE_INSERT, 2,   5,       1, 1, 0, 0, 0); // past count+1
        plan[4]  = make_row(MODE_SPARE,  1,   5,       1, 1, 0, 0, 0); // unused mode
        plan[5]  = make_row(MODE_INSERT, 1,   VAL_MAX, 1, 0, 0, 0, 1);
        plan[6]  = make_row(MODE_INSERT, 2,   VAL_MIN, 1, 0, 0, 0, 2);
        plan[7]  = make_row(MODE_INSERT, 1,   VAL_NEG, 1, 0, 0, 0, 3);
        plan[8]  = make_row(MODE_INSERT, 3,   0,       0, 0, 0, 0, 0); // middle insert
        plan[9]  = make_row(MODE_SEARCH, 0,   VAL_NEG, 1, 0, 1, 0, 4);
        plan[10] = make_row(MODE_SEARCH, 0,   VAL_MIN, 1, 0, 1, 3, 4);
        plan[11] = make_row(MODE_SEARCH, 0,   0,       1, 0, 1, 2, 4);
        plan[12] = make_row(MODE_SEARCH, 0,   1,       1, 0, 0, 0, 4);
        plan[13] = make_row(MODE_INSERT, 5,   0,       1, 0, 0, 0, 5); // append at count+1
        plan[14] = make_row(MODE_SEARCH, 0,   0,       1, 0, 1, 2, 5); // first of two matches
        plan[15] = make_row(MODE_DELETE, 6,   0,       1, 1, 0, 0, 5); // past count
        plan[16] = make_row(MODE_DELETE, 0,   0,       1, 1, 0, 0, 5); // position zero
        plan[17] = make_row(MODE_INSERT, 127, VAL_MAX, 1, 1, 0, 0, 5); // all position bits
        plan[18] = make_row(MODE_DELETE, 1,   0,       0, 0, 0, 0, 0); // drop the head
        plan[19] = make_row(MODE_DELETE, 4,   0,       0, 0, 0, 0, 0); // drop the tail
        plan[20] = make_row(MODE_SEARCH, 127, VAL_MAX, 1, 0, 1, 0, 3); // position ignored
        plan[21] = make_row(MODE_SEARCH, 0,   0,       0, 0, 0, 0, 0);
        plan[22] = make_row(MODE_SPARE,  0,   VAL_MIN, 1, 1, 0, 0, 3);
        plan[23] = make_row(MODE_DELETE, 2,   0,       0, 0, 0, 0, 0);

        // Hold reset, then release it away from the active edge.
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_request(plan[k].rq, pick_gap(), plan[k].typed, plan[k].want);

        // Random phases: each leans toward filling, draining, mixing or
        // searching, so the list sweeps between empty and full many times.
        // Some phases run with no gap between requests.
        n_random = 0;
        while (n_random < N_RANDOM)
        begin
            ph     = phase_t'($urandom_range(0, 3));
            ph_len = $urandom_range(30, 150);
            burst  = ($urandom_range(0, 3) == 0);
            repeat (ph_len)
            begin
                rq.mode     = pick_mode(ph);
                rq.position = pick_position(rq.mode);
                rq.value    = pick_value(rq.mode);
                send_request(rq, burst ? 0 : pick_gap(), 1'b0, '0);
                n_random++;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain what is still owed, then watch a while longer for strays.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("Covered %0d requests (%0d from the directed table): %0d rejected, %0d search hits,",
                 n_sent, N_DIRECTED, n_rejects, n_hits);
        $display("peak length %0d, %0d inserts into a full list, requests stalled %0d cycles.",
                 peak_len, n_full_inserts, n_in_stalls);
        if (n_errors == 0)
            $display("tb_positional_list_insert_delete_search: done, clean");
        else
            $display("tb_positional_list_insert_delete_search: done, errors");
        $finish;
    end

endmodule
